### hw/rtl/assert_macros.svh
// Assertion macros shared by the AES block mode engine modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define AESBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define AESBM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### hw/rtl/aesbm_pkg.sv
// Types, constants, tables and round functions of the AES block mode engine.
`timescale 1ns / 1ps
package aesbm_pkg;

  localparam int QDEPTH = 2;
  localparam int QAW = $clog2(QDEPTH);
  localparam int NR_MAX = 14;
  localparam int APB_AW = 6;

  localparam logic [3:0] NR_128 = 4'd10;
  localparam logic [3:0] NR_256 = 4'd14;
  localparam logic [4:0] BLOCK_BYTES = 5'd16;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOKEY = 2'd1;
  localparam logic [1:0] ST_PARTIAL = 2'd2;

  localparam logic [1:0] MODE_ECB = 2'd0;
  localparam logic [1:0] MODE_CBC = 2'd1;
  localparam logic [1:0] MODE_CTR = 2'd2;

  localparam logic [1:0] KL_128 = 2'd1;
  localparam logic [1:0] KL_256 = 2'd2;

  localparam logic [2:0] REG_KEY0 = 3'd0;
  localparam logic [2:0] REG_KEY1 = 3'd1;
  localparam logic [2:0] REG_KEY2 = 3'd2;
  localparam logic [2:0] REG_KEY3 = 3'd3;
  localparam logic [2:0] REG_KEY_LENGTH = 3'd4;
  localparam logic [2:0] REG_CIPHER_MODE = 3'd5;
  localparam logic [2:0] REG_DECRYPT = 3'd6;

  localparam logic [0:0] ACT_LOAD = 1'b0;

  typedef enum logic [3:0] {
    OP_LOAD, OP_NOKEY, OP_EMPTY, OP_PARTIAL,
    OP_ECB_ENC, OP_ECB_DEC, OP_CBC_ENC, OP_CBC_DEC, OP_CTR
  } op_t;

  typedef enum logic [1:0] {BK_IDLE, BK_KEYEXP, BK_ROUND, BK_DONE} bk_state_t;

  typedef struct packed {
    op_t          op;
    logic [127:0] data;
    logic [4:0]   nbytes;
  } cmd_t;

  typedef struct packed {
    logic [1:0] key_length;
    logic [1:0] cipher_mode;
    logic       decrypt;
  } front_cfg_t;

  typedef struct packed {
    logic [255:0] key;
    logic [1:0]   key_length;
    logic         key_upd;
  } key_cfg_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // One encryption round: SubBytes, ShiftRows, MixColumns unless last, AddRoundKey.
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i + 4 * c] = SBOX[s[127 - 8 * (i + 4 * ((c + i) & 3)) -: 8]];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4 * c];
        a1 = t[4 * c + 1];
        a2 = t[4 * c + 2];
        a3 = t[4 * c + 3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4 * c]     = a0 ^ al ^ xt(a0 ^ a1);
        t[4 * c + 1] = a1 ^ al ^ xt(a1 ^ a2);
        t[4 * c + 2] = a2 ^ al ^ xt(a2 ^ a3);
        t[4 * c + 3] = a3 ^ al ^ xt(a3 ^ a0);
      end
    end
    for (int k = 0; k < 16; k++) begin
      r[127 - 8 * k -: 8] = t[k];
    end
    return r ^ rk;
  endfunction

  function automatic logic [7:0] mul9(input logic [7:0] a);
    return xt(xt(xt(a))) ^ a;
  endfunction

  function automatic logic [7:0] mul11(input logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(a) ^ a;
  endfunction

  function automatic logic [7:0] mul13(input logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(xt(a)) ^ a;
  endfunction

  function automatic logic [7:0] mul14(input logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(xt(a)) ^ xt(a);
  endfunction

  // One decryption round: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns unless last.
  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] u;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i + 4 * ((c + i) & 3)] = INV_SBOX[s[127 - 8 * (i + 4 * c) -: 8]];
      end
    end
    for (int k = 0; k < 16; k++) begin
      u[127 - 8 * k -: 8] = t[k];
    end
    u = u ^ rk;
    r = u;
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = u[127 - 32 * c -: 8];
        a1 = u[119 - 32 * c -: 8];
        a2 = u[111 - 32 * c -: 8];
        a3 = u[103 - 32 * c -: 8];
        r[127 - 32 * c -: 8] = mul14(a0) ^ mul11(a1) ^ mul13(a2) ^ mul9(a3);
        r[119 - 32 * c -: 8] = mul9(a0) ^ mul14(a1) ^ mul11(a2) ^ mul13(a3);
        r[111 - 32 * c -: 8] = mul13(a0) ^ mul9(a1) ^ mul14(a2) ^ mul11(a3);
        r[103 - 32 * c -: 8] = mul11(a0) ^ mul13(a1) ^ mul9(a2) ^ mul14(a3);
      end
    end
    return r;
  endfunction

  // Next round key from the key Nk words back and the last word produced.
  function automatic logic [127:0] key_step(input logic [127:0] base, input logic [127:0] prev,
                                            input logic [7:0] rcon, input logic rot);
    logic [31:0] t, w0, w1, w2, w3;
    if (rot) begin
      t = {SBOX[prev[23:16]] ^ rcon, SBOX[prev[15:8]], SBOX[prev[7:0]], SBOX[prev[31:24]]};
    end else begin
      t = {SBOX[prev[31:24]], SBOX[prev[23:16]], SBOX[prev[15:8]], SBOX[prev[7:0]]};
    end
    w0 = base[127:96] ^ t;
    w1 = base[95:64] ^ w0;
    w2 = base[63:32] ^ w1;
    w3 = base[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

### hw/rtl/aesbm_queue.sv
// Short command queue between the classifying front end and the cipher back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module aesbm_queue
  import aesbm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  cmd_t           slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full  = (count == (QAW + 1)'(QDEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  `AESBM_ASSERT_NEVER(a_q_overflow, push && !pop && full, "queue written while full")
  `AESBM_ASSERT_NEVER(a_q_underflow, pop && !valid, "queue read while empty")

endmodule

### hw/rtl/aesbm_front.sv
// Front end: takes input words and sorts each into one back-end operation.
`timescale 1ns / 1ps
module aesbm_front
  import aesbm_pkg::*;
(
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         in_action,
  input  logic [127:0] in_data,
  input  logic [4:0]   in_count,
  input  front_cfg_t   cfg,
  input  logic         q_full,
  output logic         push,
  output cmd_t         push_cmd
);

  logic [4:0] nbytes;
  logic       key_ok;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;
  assign nbytes   = (in_count > BLOCK_BYTES) ? BLOCK_BYTES : in_count;
  assign key_ok   = (cfg.key_length == KL_128) || (cfg.key_length == KL_256);

  always_comb begin
    push_cmd.data   = in_data;
    push_cmd.nbytes = nbytes;
    if (in_action == ACT_LOAD) begin
      push_cmd.op = OP_LOAD;
    end else if (!key_ok) begin
      push_cmd.op = OP_NOKEY;
    end else if (nbytes == '0) begin
      push_cmd.op = OP_EMPTY;
    end else if (cfg.cipher_mode == MODE_CTR) begin
      push_cmd.op = OP_CTR;
    end else if (nbytes != BLOCK_BYTES) begin
      push_cmd.op = OP_PARTIAL;
    end else if (cfg.cipher_mode == MODE_CBC) begin
      push_cmd.op = cfg.decrypt ? OP_CBC_DEC : OP_CBC_ENC;
    end else begin
      // The unused mode code runs as ECB.
      push_cmd.op = cfg.decrypt ? OP_ECB_DEC : OP_ECB_ENC;
    end
  end

endmodule

### hw/rtl/aesbm_back.sv
// Back end: round key expansion, one AES round per cycle, chaining and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module aesbm_back
  import aesbm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  key_cfg_t     kcfg,
  input  logic         q_valid,
  input  cmd_t         q_head,
  output logic         q_pop,
  input  logic         out_ready,
  output logic         out_valid,
  output logic [127:0] out_text,
  output logic [127:0] out_chain,
  output logic [1:0]   out_status
);

  bk_state_t    bk_state, bk_state_next;
  logic [127:0] rk [NR_MAX + 1];
  logic [3:0]   rnd;
  logic [3:0]   nr_q;
  logic [3:0]   kidx;
  logic [127:0] prev1, prev2;
  logic [7:0]   rcon;
  logic         key_stale;
  logic [127:0] st, blk, chain;
  op_t          op;
  logic [4:0]   nb;

  logic         head_cipher, head_dec, cur_dec, key256, out_free, last_round;
  logic         start_exp, start_blk, idle_emit, out_load, kexp_rot;
  logic [3:0]   rd_idx;
  logic [127:0] rk_rd, round_out, kexp_new, init_state, done_text, done_chain, ctr_x;

  assign head_cipher = (q_head.op == OP_ECB_ENC) || (q_head.op == OP_ECB_DEC) ||
                       (q_head.op == OP_CBC_ENC) || (q_head.op == OP_CBC_DEC) ||
                       (q_head.op == OP_CTR);
  assign head_dec    = (q_head.op == OP_ECB_DEC) || (q_head.op == OP_CBC_DEC);
  assign cur_dec     = (op == OP_ECB_DEC) || (op == OP_CBC_DEC);
  assign key256      = (kcfg.key_length == KL_256);
  assign out_free    = !out_valid || out_ready;
  assign last_round  = cur_dec ? (rnd == '0) : (rnd == nr_q);

  // Single read port into the round key store.
  assign rd_idx = (bk_state == BK_IDLE) ? (head_dec ? nr_q : '0) : rnd;
  assign rk_rd  = rk[rd_idx];

  assign round_out = cur_dec ? dec_round(st, rk_rd, rnd == '0)
                             : enc_round(st, rk_rd, rnd == nr_q);

  // AES-256 alternates between the rotated and the plain substitution step.
  assign kexp_rot = !key256 || !kidx[0];
  assign kexp_new = key_step(key256 ? prev2 : prev1, prev1, rcon, kexp_rot);

  always_comb begin
    case (q_head.op)
      OP_CBC_ENC: init_state = q_head.data ^ chain;
      OP_CTR:     init_state = chain;
      default:    init_state = q_head.data;
    endcase
  end

  always_comb begin
    ctr_x = st ^ blk;
    for (int k = 0; k < 16; k++) begin
      if (5'(k) >= nb) begin
        ctr_x[127 - 8 * k -: 8] = 8'h00;
      end
    end
    case (op)
      OP_CBC_ENC: begin
        done_text  = st;
        done_chain = st;
      end
      OP_CBC_DEC: begin
        done_text  = st ^ chain;
        done_chain = blk;
      end
      OP_CTR: begin
        done_text  = ctr_x;
        done_chain = chain + 128'd1;
      end
      default: begin
        done_text  = st;
        done_chain = chain;
      end
    endcase
  end

  always_comb begin
    bk_state_next = bk_state;
    q_pop         = 1'b0;
    start_exp     = 1'b0;
    start_blk     = 1'b0;
    idle_emit     = 1'b0;
    out_load      = 1'b0;
    case (bk_state)
      BK_IDLE: begin
        if (q_valid) begin
          if (head_cipher) begin
            if (key_stale) begin
              start_exp     = 1'b1;
              bk_state_next = BK_KEYEXP;
            end else begin
              q_pop         = 1'b1;
              start_blk     = 1'b1;
              bk_state_next = BK_ROUND;
            end
          end else if (out_free) begin
            q_pop     = 1'b1;
            idle_emit = 1'b1;
            out_load  = 1'b1;
          end
        end
      end
      BK_KEYEXP: begin
        if (kidx == nr_q) begin
          bk_state_next = BK_IDLE;
        end
      end
      BK_ROUND: begin
        if (last_round) begin
          bk_state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          out_load      = 1'b1;
          bk_state_next = BK_IDLE;
        end
      end
      default: bk_state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bk_state  <= BK_IDLE;
      key_stale <= 1'b1;
      out_valid <= 1'b0;
      chain     <= '0;
    end else begin
      bk_state <= bk_state_next;
      if (kcfg.key_upd) begin
        key_stale <= 1'b1;
      end else if (bk_state == BK_KEYEXP && kidx == nr_q) begin
        key_stale <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (idle_emit && q_head.op == OP_LOAD) begin
        chain <= q_head.data;
      end else if (bk_state == BK_DONE && out_load) begin
        chain <= done_chain;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_exp) begin
      rk[0] <= kcfg.key[255:128];
      rk[1] <= kcfg.key[127:0];
      prev2 <= kcfg.key[255:128];
      prev1 <= key256 ? kcfg.key[127:0] : kcfg.key[255:128];
      kidx  <= key256 ? 4'd2 : 4'd1;
      nr_q  <= key256 ? NR_256 : NR_128;
      rcon  <= 8'h01;
    end else if (bk_state == BK_KEYEXP) begin
      rk[kidx] <= kexp_new;
      prev2    <= prev1;
      prev1    <= kexp_new;
      if (kidx != nr_q) begin
        kidx <= kidx + 1'b1;
      end
      if (kexp_rot) begin
        rcon <= xt(rcon);
      end
    end

    if (start_blk) begin
      st  <= init_state ^ rk_rd;
      blk <= q_head.data;
      op  <= q_head.op;
      nb  <= q_head.nbytes;
      rnd <= head_dec ? nr_q - 1'b1 : 4'd1;
    end else if (bk_state == BK_ROUND) begin
      st <= round_out;
      if (!last_round) begin
        rnd <= cur_dec ? rnd - 1'b1 : rnd + 1'b1;
      end
    end

    if (out_load) begin
      if (idle_emit) begin
        out_text  <= '0;
        out_chain <= (q_head.op == OP_LOAD) ? q_head.data : chain;
        case (q_head.op)
          OP_NOKEY:   out_status <= ST_NOKEY;
          OP_PARTIAL: out_status <= ST_PARTIAL;
          default:    out_status <= ST_OK;
        endcase
      end else begin
        out_text   <= done_text;
        out_chain  <= done_chain;
        out_status <= ST_OK;
      end
    end
  end

  `AESBM_ASSERT(a_rnd_range, (bk_state == BK_ROUND) |-> (rnd <= nr_q), "round index past last round")
  `AESBM_ASSERT(a_kidx_range, (bk_state == BK_KEYEXP) |-> (kidx <= nr_q), "key index past last round key")
  `AESBM_ASSERT_NEVER(a_out_overrun, out_load && out_valid && !out_ready, "result overwritten before taken")

endmodule

### hw/rtl/aes_block_mode_engine_core.sv
// A load or error word goes from the queue head straight into the result register; a block
// has a start step, one AES round per cycle and a chaining step that waits for a free output.
// The single shared round unit finishes one block before it starts the next.
// The first block after a key change first waits for key expansion.
// Reset (synchronous, active high) clears registers, chaining value and queue.
`timescale 1ns / 1ps
module aes_block_mode_engine_core
  import aesbm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [135:0]      s_tdata,  // data_hi, data_lo, byte_count, zero fill
  input  logic [0:0]        s_tuser,  // action
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [255:0]      m_tdata,  // text_hi, text_lo, chain_out_hi, chain_out_lo
  output logic [1:0]        m_tuser,  // status
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  logic [63:0] key_word0, key_word1, key_word2, key_word3;
  logic [1:0]  key_length, cipher_mode;
  logic        decrypt;
  logic        wr_en;
  logic [2:0]  reg_idx;

  front_cfg_t   fcfg;
  key_cfg_t     kcfg;
  logic         q_full, q_push, q_pop, q_valid;
  cmd_t         q_in, q_head;
  logic [127:0] out_text, out_chain;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word0   <= '0;
      key_word1   <= '0;
      key_word2   <= '0;
      key_word3   <= '0;
      key_length  <= '0;
      cipher_mode <= '0;
      decrypt     <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_KEY0:        key_word0 <= pwdata;
        REG_KEY1:        key_word1 <= pwdata;
        REG_KEY2:        key_word2 <= pwdata;
        REG_KEY3:        key_word3 <= pwdata;
        REG_KEY_LENGTH:  key_length <= pwdata[1:0];
        REG_CIPHER_MODE: cipher_mode <= pwdata[1:0];
        REG_DECRYPT:     decrypt <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KEY0:        prdata = key_word0;
      REG_KEY1:        prdata = key_word1;
      REG_KEY2:        prdata = key_word2;
      REG_KEY3:        prdata = key_word3;
      REG_KEY_LENGTH:  prdata = {62'd0, key_length};
      REG_CIPHER_MODE: prdata = {62'd0, cipher_mode};
      REG_DECRYPT:     prdata = {63'd0, decrypt};
      default:         prdata = '0;
    endcase
  end

  assign fcfg.key_length  = key_length;
  assign fcfg.cipher_mode = cipher_mode;
  assign fcfg.decrypt     = decrypt;

  // Any write to a key word or the key length forces a fresh expansion.
  assign kcfg.key        = {key_word0, key_word1, key_word2, key_word3};
  assign kcfg.key_length = key_length;
  assign kcfg.key_upd    = wr_en && (reg_idx == REG_KEY0 || reg_idx == REG_KEY1 ||
                                     reg_idx == REG_KEY2 || reg_idx == REG_KEY3 ||
                                     reg_idx == REG_KEY_LENGTH);

  aesbm_front u_front (
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_action (s_tuser[0]),
    .in_data   ({s_tdata[63:0], s_tdata[127:64]}),
    .in_count  (s_tdata[132:128]),
    .cfg       (fcfg),
    .q_full    (q_full),
    .push      (q_push),
    .push_cmd  (q_in)
  );

  aesbm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  aesbm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .kcfg       (kcfg),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_text   (out_text),
    .out_chain  (out_chain),
    .out_status (m_tuser)
  );

  // data_hi arrives in the low half of tdata, so swap halves into byte order.
  assign m_tdata = {out_chain[63:0], out_chain[127:64], out_text[63:0], out_text[127:64]};

endmodule
